### design/lhrb_pkg.sv
// Shared types and constants of the line history ring buffer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lhrb_pkg;

	// default sizing of the history store
	localparam int MAX_LINES_DEF = 256;
	localparam int MAX_COLS_DEF  = 64;

	// field and register widths
	localparam int CP_W         = 21;
	localparam int FUNC_W       = 2;
	localparam int IDX_W        = 8;
	localparam int LIM_W        = 7;
	localparam int TOTAL_W      = 32;
	localparam int WIDTH_CFG_W  = 7;
	localparam int CAP_CFG_W    = 9;
	localparam int CFG_DATA_W   = 9;
	localparam int CFG_IDX_W    = 1;

	// widest internal fields over the whole parameter range
	localparam int ADDR_MAX_W   = 18;
	localparam int CNT_MAX_W    = 13;

	// queue between front and back
	localparam int Q_DEPTH      = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LINES_IN_USE = 1'b1;

	localparam logic [WIDTH_CFG_W-1:0] LINE_WIDTH_RST   = 7'd64;
	localparam logic [CAP_CFG_W-1:0]   LINES_IN_USE_RST = 9'd256;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH  = 2'd0,
		FN_GET   = 2'd1,
		FN_CLEAR = 2'd2,
		FN_RESET = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		K_WRITE,
		K_SINGLE,
		K_STREAM
	} kind_t;

	typedef enum logic [1:0] {
		F_RUN,
		F_HEAD,
		F_IDX
	} front_state_t;

	// one classified operation handed from front to back
	typedef struct packed {
		kind_t                  kind;
		logic [ADDR_MAX_W-1:0]  addr;
		logic [CP_W-1:0]        data;
		logic                   ok;
		logic [LIM_W-1:0]       len;
		logic [CNT_MAX_W-1:0]   count;
		logic [TOTAL_W-1:0]     total;
	} q_entry_t;

	typedef struct packed {
		logic start;
		logic abort;
	} rem_ctl_t;

endpackage

`default_nettype wire

### design/lhrb_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Uses lhrb_pkg for its control struct.
`default_nettype none

module lhrb_rem #(
	parameter int DVD_W = 8,
	parameter int DSR_W = 9
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lhrb_pkg::rem_ctl_t  ctl,
	input  wire logic [DVD_W-1:0]    dividend,
	input  wire logic [DSR_W-1:0]    divisor,
	output logic                     done,
	output logic [DSR_W-1:0]         rem
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DSR_W-1:0] rem_q;

	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic [DSR_W-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, dvd_q[DVD_W-1]};
		diff    = trial - {1'b0, divisor};
		rem_nxt = (trial >= {1'b0, divisor}) ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.abort) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CNT_W'(1));
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

### design/lhrb_front.sv
// Front end: configuration registers, history counters and item classification.
// Uses lhrb_pkg and lhrb_rem; feeds q_entry_t operations to the queue.
`default_nettype none

module lhrb_front #(
	parameter int MAX_LINES = lhrb_pkg::MAX_LINES_DEF,
	parameter int MAX_COLS  = lhrb_pkg::MAX_COLS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [lhrb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [lhrb_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [lhrb_pkg::FUNC_W-1:0]          func,
	input  wire logic [lhrb_pkg::CP_W-1:0]            codepoint,
	input  wire logic [lhrb_pkg::IDX_W-1:0]           line_index,
	input  wire logic [lhrb_pkg::LIM_W-1:0]           copy_limit,
	input  wire logic                                 q_full,
	output logic                                      q_push,
	output lhrb_pkg::q_entry_t                        q_entry
);

	localparam int SLOT_W = $clog2(MAX_LINES);
	localparam int CNT_W  = $clog2(MAX_LINES + 1);
	localparam int CW     = (CNT_W > lhrb_pkg::CAP_CFG_W) ? CNT_W : lhrb_pkg::CAP_CFG_W;
	localparam int TW     = CW + 1;
	localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ADDR_W = $clog2(MAX_LINES * MAX_COLS);
	localparam int DVD_W  = (SLOT_W > lhrb_pkg::IDX_W) ? SLOT_W : lhrb_pkg::IDX_W;
	localparam int WW     = lhrb_pkg::WIDTH_CFG_W;

	// configuration
	logic [WW-1:0]                   line_width_q;
	logic [lhrb_pkg::CAP_CFG_W-1:0]  lines_q;

	// history state
	logic [SLOT_W-1:0]               head_q;
	logic                            head_ok_q;
	logic [CNT_W-1:0]                count_q;
	logic [COL_W-1:0]                col_q;
	logic [lhrb_pkg::TOTAL_W-1:0]    total_q;
	logic [lhrb_pkg::IDX_W-1:0]      idxr_q;
	logic                            idxr_ok_q;
	lhrb_pkg::front_state_t          state_q;
	lhrb_pkg::front_state_t          state_nxt;

	logic                            cap_wr;
	logic [WW-1:0]                   width_eff;
	logic [CW-1:0]                   cap_ext;
	logic [CW-1:0]                   cap_cw;
	logic [CNT_W-1:0]                cap_eff;
	logic                            head_lt_cap;
	logic                            idx_lt_cnt;
	logic                            idx_ge_cap;
	logic                            need_idx;
	logic                            want_head;
	logic                            want_idx;
	logic                            accept;

	lhrb_pkg::rem_ctl_t              mod_ctl;
	logic [DVD_W-1:0]                mod_dvd;
	logic                            mod_done;
	logic [CNT_W-1:0]                mod_rem;

	// item results
	logic [lhrb_pkg::IDX_W-1:0]      age_r;
	logic [TW-1:0]                   t_sum;
	logic [TW-1:0]                   t_slot;
	logic [SLOT_W-1:0]               get_slot;
	logic [WW-1:0]                   n_copy;
	logic [WW-1:0]                   col_inc;
	logic                            commit;
	logic [SLOT_W-1:0]               head_nxt;
	logic [CNT_W-1:0]                count_nxt;
	logic [COL_W-1:0]                col_nxt;
	logic [lhrb_pkg::TOTAL_W-1:0]    total_nxt;
	logic [ADDR_W-1:0]               addr;
	lhrb_pkg::q_entry_t              ent;

	always_comb begin
		cap_wr = cfg_wr_en && (cfg_index == lhrb_pkg::REG_LINES_IN_USE);

		if (line_width_q == '0) begin
			width_eff = WW'(1);
		end else if (line_width_q > WW'(MAX_COLS)) begin
			width_eff = WW'(MAX_COLS);
		end else begin
			width_eff = line_width_q;
		end

		cap_ext = CW'(lines_q);
		if (cap_ext == '0) begin
			cap_cw = CW'(1);
		end else if (cap_ext > CW'(MAX_LINES)) begin
			cap_cw = CW'(MAX_LINES);
		end else begin
			cap_cw = cap_ext;
		end
		cap_eff = CNT_W'(cap_cw);

		head_lt_cap = CW'(head_q) < cap_cw;
		idx_lt_cnt  = CW'(line_index) < CW'(count_q);
		idx_ge_cap  = CW'(line_index) >= cap_cw;
		need_idx    = in_valid && (func == lhrb_pkg::FN_GET) && idx_lt_cnt && idx_ge_cap;

		want_head = !head_ok_q && !head_lt_cap;
		want_idx  = head_ok_q && need_idx && !idxr_ok_q;

		in_stall = !((state_q == lhrb_pkg::F_RUN) && head_ok_q && !cfg_wr_en && !q_full &&
			(!need_idx || idxr_ok_q));
		accept   = in_valid && !in_stall;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lhrb_pkg::F_RUN: begin
				if (!cap_wr && want_head) begin
					state_nxt = lhrb_pkg::F_HEAD;
				end else if (!cap_wr && want_idx) begin
					state_nxt = lhrb_pkg::F_IDX;
				end
			end
			lhrb_pkg::F_HEAD, lhrb_pkg::F_IDX: begin
				if (cap_wr || mod_done) begin
					state_nxt = lhrb_pkg::F_RUN;
				end
			end
			default: begin
				state_nxt = lhrb_pkg::F_RUN;
			end
		endcase
	end

	// remainder unit control
	always_comb begin
		mod_ctl.start = (state_q == lhrb_pkg::F_RUN) && !cap_wr && (want_head || want_idx);
		mod_ctl.abort = cap_wr;
		mod_dvd       = head_ok_q ? DVD_W'(line_index) : DVD_W'(head_q);
	end

	lhrb_rem #(
		.DVD_W (DVD_W),
		.DSR_W (CNT_W)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mod_ctl),
		.dividend (mod_dvd),
		.divisor  (cap_eff),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// classify the item and work out the state it leaves
	always_comb begin
		age_r    = idx_ge_cap ? idxr_q : line_index;
		t_sum    = TW'(head_q) + TW'(cap_cw) - TW'(1) - TW'(age_r);
		t_slot   = (t_sum >= TW'(cap_cw)) ? (t_sum - TW'(cap_cw)) : t_sum;
		get_slot = SLOT_W'(t_slot);
		n_copy   = (width_eff < copy_limit) ? width_eff : copy_limit;

		col_inc  = WW'(col_q) + WW'(1);
		commit   = col_inc >= width_eff;

		head_nxt  = head_q;
		count_nxt = count_q;
		col_nxt   = col_q;
		total_nxt = total_q;
		addr      = '0;

		ent       = '0;
		ent.kind  = lhrb_pkg::K_SINGLE;
		ent.ok    = 1'b1;

		case (func)
			lhrb_pkg::FN_PUSH: begin
				addr     = ADDR_W'(ADDR_W'(head_q) * ADDR_W'(MAX_COLS)) + ADDR_W'(col_q);
				ent.kind = lhrb_pkg::K_WRITE;
				ent.data = codepoint;
				if (commit) begin
					col_nxt   = '0;
					head_nxt  = ((CW'(head_q) + CW'(1)) == cap_cw) ? '0 : head_q + 1'b1;
					count_nxt = (CW'(count_q) < cap_cw) ? count_q + 1'b1 : count_q;
					total_nxt = total_q + 1'b1;
				end else begin
					col_nxt   = COL_W'(col_inc);
				end
			end
			lhrb_pkg::FN_GET: begin
				addr = ADDR_W'(ADDR_W'(get_slot) * ADDR_W'(MAX_COLS));
				if (!idx_lt_cnt) begin
					ent.ok = 1'b0;
				end else if (n_copy != '0) begin
					ent.kind = lhrb_pkg::K_STREAM;
					ent.len  = n_copy;
				end
			end
			lhrb_pkg::FN_CLEAR: begin
				head_nxt  = '0;
				count_nxt = '0;
				col_nxt   = '0;
			end
			lhrb_pkg::FN_RESET: begin
				head_nxt  = '0;
				count_nxt = '0;
				col_nxt   = '0;
				total_nxt = '0;
			end
			default: begin
				head_nxt  = head_q;
			end
		endcase

		ent.addr  = lhrb_pkg::ADDR_MAX_W'(addr);
		ent.count = lhrb_pkg::CNT_MAX_W'(count_nxt);
		ent.total = total_nxt;
	end

	assign q_push  = accept;
	assign q_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= lhrb_pkg::LINE_WIDTH_RST;
			lines_q      <= lhrb_pkg::LINES_IN_USE_RST;
			state_q      <= lhrb_pkg::F_RUN;
			head_q       <= '0;
			head_ok_q    <= 1'b1;
			count_q      <= '0;
			col_q        <= '0;
			total_q      <= '0;
			idxr_ok_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;

			if (cfg_wr_en && (cfg_index == lhrb_pkg::REG_LINE_WIDTH)) begin
				line_width_q <= cfg_data[WW-1:0];
			end
			if (cap_wr) begin
				lines_q <= cfg_data;
			end

			if (cap_wr) begin
				head_ok_q <= 1'b0;
			end else if ((state_q == lhrb_pkg::F_RUN) && !head_ok_q && head_lt_cap) begin
				head_ok_q <= 1'b1;
			end else if ((state_q == lhrb_pkg::F_HEAD) && mod_done) begin
				head_ok_q <= 1'b1;
				head_q    <= SLOT_W'(mod_rem);
			end

			if (cap_wr || accept) begin
				idxr_ok_q <= 1'b0;
			end else if ((state_q == lhrb_pkg::F_IDX) && mod_done) begin
				idxr_ok_q <= 1'b1;
			end

			if (accept) begin
				head_q  <= head_nxt;
				count_q <= count_nxt;
				col_q   <= col_nxt;
				total_q <= total_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == lhrb_pkg::F_IDX) && mod_done && !cap_wr) begin
			idxr_q <= lhrb_pkg::IDX_W'(mod_rem);
		end
	end

endmodule

`default_nettype wire

### design/lhrb_fifo.sv
// Short queue of classified operations between the front and the back.
// Uses lhrb_pkg for the entry type and depth.
`default_nettype none

module lhrb_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire lhrb_pkg::q_entry_t  din,
	output logic                     full,
	input  wire logic                pop,
	output logic                     valid,
	output lhrb_pkg::q_entry_t       dout
);

	localparam int QA_W = (lhrb_pkg::Q_DEPTH > 1) ? $clog2(lhrb_pkg::Q_DEPTH) : 1;

	lhrb_pkg::q_entry_t  slot_q [lhrb_pkg::Q_DEPTH];
	logic [QA_W-1:0]     wr_ptr_q;
	logic [QA_W-1:0]     rd_ptr_q;
	logic [QA_W:0]       cnt_q;
	logic                do_push;
	logic                do_pop;

	always_comb begin
		full    = cnt_q == (QA_W + 1)'(lhrb_pkg::Q_DEPTH);
		valid   = cnt_q != '0;
		do_push = push && !full;
		do_pop  = pop && valid;
		dout    = slot_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QA_W'(lhrb_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QA_W'(lhrb_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

### design/lhrb_back.sv
// Back end: line store memory, codepoint streaming and the output register.
// Uses lhrb_pkg; takes operations from lhrb_fifo.
`default_nettype none

module lhrb_back #(
	parameter int MAX_LINES = lhrb_pkg::MAX_LINES_DEF,
	parameter int MAX_COLS  = lhrb_pkg::MAX_COLS_DEF,
	parameter int CNT_W     = $clog2(MAX_LINES + 1)
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 q_valid,
	input  wire lhrb_pkg::q_entry_t                   q_entry,
	output logic                                      q_pop,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      ok,
	output logic                                      has_char,
	output logic [lhrb_pkg::CP_W-1:0]                 char_out,
	output logic                                      last,
	output logic [CNT_W-1:0]                          line_count,
	output logic [lhrb_pkg::TOTAL_W-1:0]              lines_committed
);

	localparam int DEPTH  = MAX_LINES * MAX_COLS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LW     = lhrb_pkg::LIM_W;

	logic [lhrb_pkg::CP_W-1:0]     mem [DEPTH];
	logic [lhrb_pkg::CP_W-1:0]     mem_q;

	logic                          busy_q;
	logic [ADDR_W-1:0]             addr_q;
	logic [LW-1:0]                 left_q;
	logic [CNT_W-1:0]              str_cnt_q;
	logic [lhrb_pkg::TOTAL_W-1:0]  str_tot_q;

	logic                          rd_pend_s1;
	logic                          rd_last_s1;
	logic [CNT_W-1:0]              rd_cnt_s1;
	logic [lhrb_pkg::TOTAL_W-1:0]  rd_tot_s1;

	logic                          out_valid_q;
	logic                          ok_q;
	logic                          has_char_q;
	logic [lhrb_pkg::CP_W-1:0]     char_q;
	logic                          last_q;
	logic [CNT_W-1:0]              count_q;
	logic [lhrb_pkg::TOTAL_W-1:0]  total_q;

	logic                          out_free;
	logic                          issue;
	logic                          load_rd;
	logic                          start_stream;
	logic                          take_single;
	logic                          mem_we;

	always_comb begin
		out_free     = !out_valid_q || !out_stall;
		issue        = busy_q && (!rd_pend_s1 || out_free);
		load_rd      = rd_pend_s1 && out_free;
		start_stream = !busy_q && q_valid && (q_entry.kind == lhrb_pkg::K_STREAM);
		take_single  = !busy_q && q_valid && (q_entry.kind != lhrb_pkg::K_STREAM) &&
			!rd_pend_s1 && out_free;
		mem_we       = take_single && (q_entry.kind == lhrb_pkg::K_WRITE);
		q_pop        = start_stream || take_single;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start_stream) begin
				busy_q <= 1'b1;
			end else if (issue) begin
				busy_q <= (left_q != LW'(1));
			end

			if (issue) begin
				rd_pend_s1 <= 1'b1;
			end else if (load_rd) begin
				rd_pend_s1 <= 1'b0;
			end

			if (load_rd || take_single) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_stream) begin
			addr_q    <= q_entry.addr[ADDR_W-1:0];
			left_q    <= q_entry.len;
			str_cnt_q <= CNT_W'(q_entry.count);
			str_tot_q <= q_entry.total;
		end else if (issue) begin
			addr_q <= addr_q + 1'b1;
			left_q <= left_q - 1'b1;
		end

		if (issue) begin
			rd_last_s1 <= (left_q == LW'(1));
			rd_cnt_s1  <= str_cnt_q;
			rd_tot_s1  <= str_tot_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[q_entry.addr[ADDR_W-1:0]] <= q_entry.data;
		end
		if (issue) begin
			mem_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (load_rd) begin
			ok_q       <= 1'b1;
			has_char_q <= 1'b1;
			char_q     <= mem_q;
			last_q     <= rd_last_s1;
			count_q    <= rd_cnt_s1;
			total_q    <= rd_tot_s1;
		end else if (take_single) begin
			ok_q       <= q_entry.ok;
			has_char_q <= 1'b0;
			char_q     <= '0;
			last_q     <= 1'b1;
			count_q    <= CNT_W'(q_entry.count);
			total_q    <= q_entry.total;
		end
	end

	assign out_valid       = out_valid_q;
	assign ok              = ok_q;
	assign has_char        = has_char_q;
	assign char_out        = char_q;
	assign last            = last_q;
	assign line_count      = count_q;
	assign lines_committed = total_q;

endmodule

`default_nettype wire

### design/line_history_ring_buffer_unit.sv
// Top level of the line history ring buffer: front, queue and back wired together.
// Uses lhrb_pkg, lhrb_front, lhrb_fifo and lhrb_back.
`default_nettype none

// A history of MAX_LINES text lines of up to MAX_COLS codepoints each, kept in
// one MAX_LINES*MAX_COLS entry memory that overwrites the oldest line when full.
// Push, clear, full reset and out-of-range gets each give one result, and
// back-to-back pushes flow at one codepoint per cycle while the receiver does
// not stall. A get starts its stream by loading the stream counters, then the
// registered read of the first column, and then delivers min(width, copy_limit)
// codepoints at one per cycle while the receiver does not stall, set by the
// single read port of the line store. After a write to lines_in_use, the next
// item waits while the head slot is checked against the new capacity, and also
// while the bit-serial remainder unit reduces the head slot when it must be.
// A get whose age is at or above the capacity (only after the capacity was
// lowered) waits while that same unit reduces its age. in_stall is high while
// a configuration write is presented. The store is not cleared at reset; reading
// a column that was never written gives an undefined codepoint. No clearing pass
// is run, so items are taken as soon as reset is released.

module line_history_ring_buffer_unit #(
	parameter int MAX_LINES = lhrb_pkg::MAX_LINES_DEF,
	parameter int MAX_COLS  = lhrb_pkg::MAX_COLS_DEF,
	parameter int CNT_W     = $clog2(MAX_LINES + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	// configuration write port
	input  wire logic                              cfg_wr_en,
	input  wire logic [lhrb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lhrb_pkg::CFG_DATA_W-1:0]   cfg_data,

	// input items
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [lhrb_pkg::FUNC_W-1:0]       func,
	input  wire logic [lhrb_pkg::CP_W-1:0]         codepoint,
	input  wire logic [lhrb_pkg::IDX_W-1:0]        line_index,
	input  wire logic [lhrb_pkg::LIM_W-1:0]        copy_limit,

	// result items
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   ok,
	output logic                                   has_char,
	output logic [lhrb_pkg::CP_W-1:0]              char_out,
	output logic                                   last,
	output logic [CNT_W-1:0]                       line_count,
	output logic [lhrb_pkg::TOTAL_W-1:0]           lines_committed
);

	lhrb_pkg::q_entry_t  fq_entry;
	lhrb_pkg::q_entry_t  bq_entry;
	logic                fq_push;
	logic                fq_full;
	logic                bq_valid;
	logic                bq_pop;

	// Classify each transfer, update head, count, column and total, and hand
	// the resolved operation (memory address, result values) to the queue.
	lhrb_front #(
		.MAX_LINES (MAX_LINES),
		.MAX_COLS  (MAX_COLS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.codepoint  (codepoint),
		.line_index (line_index),
		.copy_limit (copy_limit),
		.q_full     (fq_full),
		.q_push     (fq_push),
		.q_entry    (fq_entry)
	);

	// Hold operations so the front keeps taking items while the back streams.
	lhrb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.din    (fq_entry),
		.full   (fq_full),
		.pop    (bq_pop),
		.valid  (bq_valid),
		.dout   (bq_entry)
	);

	// Write codepoints, stream lines out of the store and drive the result
	// register; operations execute strictly in queue order.
	lhrb_back #(
		.MAX_LINES (MAX_LINES),
		.MAX_COLS  (MAX_COLS),
		.CNT_W     (CNT_W)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (bq_valid),
		.q_entry         (bq_entry),
		.q_pop           (bq_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.ok              (ok),
		.has_char        (has_char),
		.char_out        (char_out),
		.last            (last),
		.line_count      (line_count),
		.lines_committed (lines_committed)
	);

	// no item is taken in the cycle of a configuration write
	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |-> in_stall)
		else $error("item accepted during configuration write");

	// a failed get is a single closing result without a codepoint
	a_fail_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ok) |-> (!has_char && last))
		else $error("failed get result carries a codepoint or is not last");

	// results without a codepoint close their item and carry a zero codepoint
	a_nochar_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_char) |-> (last && (char_out == '0)))
		else $error("non-codepoint result malformed");

	// the retained line count never exceeds the store
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (line_count <= CNT_W'(MAX_LINES)))
		else $error("line count beyond store capacity");

endmodule

`default_nettype wire

### dv/lhrb_checker.sv
`timescale 1ns / 1ps
// Result checker for the line history ring buffer unit: follows register writes and
// accepted items, predicts each result and compares every result transfer.
// Depends on lhrb_pkg.

module lhrb_checker #(
	parameter int MAX_LINES = lhrb_pkg::MAX_LINES_DEF,
	parameter int MAX_COLS  = lhrb_pkg::MAX_COLS_DEF,
	parameter int CNT_W     = $clog2(MAX_LINES + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [lhrb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lhrb_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	input  wire logic                              in_stall,
	input  wire logic [lhrb_pkg::FUNC_W-1:0]       func,
	input  wire logic [lhrb_pkg::CP_W-1:0]         codepoint,
	input  wire logic [lhrb_pkg::IDX_W-1:0]        line_index,
	input  wire logic [lhrb_pkg::LIM_W-1:0]        copy_limit,
	input  wire logic                              out_valid,
	input  wire logic                              out_stall,
	input  wire logic                              ok,
	input  wire logic                              has_char,
	input  wire logic [lhrb_pkg::CP_W-1:0]         char_out,
	input  wire logic                              last,
	input  wire logic [CNT_W-1:0]                  line_count,
	input  wire logic [lhrb_pkg::TOTAL_W-1:0]      lines_committed,
	output int unsigned                            fail_count,
	output int unsigned                            outstanding
);

	typedef struct packed {
		logic                         ok;
		logic                         has_char;
		logic [lhrb_pkg::CP_W-1:0]    ch;
		logic                         last;
		logic [CNT_W-1:0]             count;
		logic [lhrb_pkg::TOTAL_W-1:0] total;
	} line_result_t;

	line_result_t              results_due [$];
	line_result_t              oldest;
	logic [lhrb_pkg::CP_W-1:0] hist_store [MAX_LINES*MAX_COLS];

	int unsigned head_slot    = 0;
	int unsigned kept_lines   = 0;
	int unsigned lines_total  = 0;
	int unsigned build_col    = 0;
	int unsigned width_raw    = 32'(lhrb_pkg::LINE_WIDTH_RST);
	int unsigned cap_raw      = 32'(lhrb_pkg::LINES_IN_USE_RST);
	int unsigned mismatches   = 0;

	assign fail_count = mismatches;

	function automatic int unsigned width_now();
		if (width_raw < 1) return 1;
		if (width_raw > MAX_COLS) return MAX_COLS;
		return width_raw;
	endfunction

	function automatic int unsigned cap_now();
		if (cap_raw < 1) return 1;
		if (cap_raw > MAX_LINES) return MAX_LINES;
		return cap_raw;
	endfunction

	function automatic line_result_t make_result(input logic good, input logic has,
			input logic [lhrb_pkg::CP_W-1:0] ch, input logic fin);
		line_result_t r;
		r.ok       = good;
		r.has_char = has;
		r.ch       = ch;
		r.last     = fin;
		r.count    = kept_lines[CNT_W-1:0];
		r.total    = lines_total;
		return r;
	endfunction

	// advance the history by one item and queue the results it gives
	task automatic predict_item(input lhrb_pkg::func_t f, input logic [lhrb_pkg::CP_W-1:0] cp,
			input logic [lhrb_pkg::IDX_W-1:0] idx, input logic [lhrb_pkg::LIM_W-1:0] lim);
		int unsigned cap;
		int unsigned width;
		int unsigned slot;
		int unsigned col;
		int unsigned n;
		cap   = cap_now();
		width = width_now();
		case (f)
		lhrb_pkg::FN_PUSH: begin
			slot = head_slot % cap;
			col  = build_col % MAX_COLS;
			hist_store[slot*MAX_COLS + col] = cp;
			if (col + 1 >= width) begin
				build_col = 0;
				head_slot = (slot + 1) % cap;
				if (kept_lines < cap)
					kept_lines++;
				lines_total++;
			end else begin
				build_col = col + 1;
			end
			results_due.push_back(make_result(1'b1, 1'b0, '0, 1'b1));
		end
		lhrb_pkg::FN_GET: begin
			n = (width < lim) ? width : lim;
			if (idx >= kept_lines) begin
				results_due.push_back(make_result(1'b0, 1'b0, '0, 1'b1));
			end else if (n == 0) begin
				results_due.push_back(make_result(1'b1, 1'b0, '0, 1'b1));
			end else begin
				// ages at or above the capacity wrap onto the slots in use
				slot = ((head_slot % cap) + 2*cap - 1 - (idx % cap)) % cap;
				for (int unsigned c = 0; c < n; c++)
					results_due.push_back(make_result(1'b1, 1'b1,
						hist_store[slot*MAX_COLS + c], c + 1 == n));
			end
		end
		default: begin
			head_slot  = 0;
			kept_lines = 0;
			build_col  = 0;
			if (f == lhrb_pkg::FN_RESET)
				lines_total = 0;
			results_due.push_back(make_result(1'b1, 1'b0, '0, 1'b1));
		end
		endcase
	endtask

	task automatic report_field(input string what, input logic [31:0] want,
			input logic [31:0] seen);
		mismatches++;
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_due.delete();
			head_slot   = 0;
			kept_lines  = 0;
			lines_total = 0;
			build_col   = 0;
			width_raw   = 32'(lhrb_pkg::LINE_WIDTH_RST);
			cap_raw     = 32'(lhrb_pkg::LINES_IN_USE_RST);
			outstanding <= 0;
		end else begin
			// compare before predicting, so a result never meets an item of the same edge
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing expected, expected none, got char_out %0h last %0b",
						$time, char_out, last);
				end else begin
					oldest = results_due.pop_front();
					if (ok !== oldest.ok)
						report_field("ok", oldest.ok, ok);
					if (has_char !== oldest.has_char)
						report_field("has_char", oldest.has_char, has_char);
					if (char_out !== oldest.ch)
						report_field("char_out", oldest.ch, char_out);
					if (last !== oldest.last)
						report_field("last", oldest.last, last);
					if (line_count !== oldest.count)
						report_field("line_count", oldest.count, line_count);
					if (lines_committed !== oldest.total)
						report_field("lines_committed", oldest.total, lines_committed);
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
				lhrb_pkg::REG_LINE_WIDTH:
					width_raw = 32'(cfg_data[lhrb_pkg::WIDTH_CFG_W-1:0]);
				lhrb_pkg::REG_LINES_IN_USE:
					cap_raw   = 32'(cfg_data[lhrb_pkg::CAP_CFG_W-1:0]);
				default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_item(lhrb_pkg::func_t'(func), codepoint, line_index, copy_limit);
			outstanding <= results_due.size();
		end
	end

endmodule

### dv/line_history_ring_buffer_unit_test.sv
`timescale 1ns / 1ps
// Testbench top of line_history_ring_buffer_unit: clock, reset, register phases,
// item stimulus and receiver stalls around the block and its checker.
// Depends on lhrb_pkg, line_history_ring_buffer_unit and lhrb_checker.

module line_history_ring_buffer_unit_test;

	localparam int LINES       = lhrb_pkg::MAX_LINES_DEF;
	localparam int COLS        = lhrb_pkg::MAX_COLS_DEF;
	localparam int CNT_W       = $clog2(LINES + 1);
	localparam int PHASES      = 8;
	localparam int LONG_HOLD   = 250;
	localparam int DRAIN_SLACK = 16;
	localparam logic [lhrb_pkg::CP_W-1:0] CP_TOP = 21'd1114111;

	logic                              clk        = 1'b0;
	logic                              arst_n     = 1'b0;
	logic                              cfg_wr_en  = 1'b0;
	logic [lhrb_pkg::CFG_IDX_W-1:0]    cfg_index  = lhrb_pkg::REG_LINE_WIDTH;
	logic [lhrb_pkg::CFG_DATA_W-1:0]   cfg_data   = '0;
	logic                              in_valid   = 1'b0;
	logic                              in_stall;
	logic [lhrb_pkg::FUNC_W-1:0]       func       = lhrb_pkg::FN_PUSH;
	logic [lhrb_pkg::CP_W-1:0]         codepoint  = '0;
	logic [lhrb_pkg::IDX_W-1:0]        line_index = '0;
	logic [lhrb_pkg::LIM_W-1:0]        copy_limit = '0;
	logic                              out_valid;
	logic                              out_stall  = 1'b0;
	logic                              ok;
	logic                              has_char;
	logic [lhrb_pkg::CP_W-1:0]         char_out;
	logic                              last;
	logic [CNT_W-1:0]                  line_count;
	logic [lhrb_pkg::TOTAL_W-1:0]      lines_committed;
	int unsigned                       fail_count;
	int unsigned                       outstanding;

	// Position of the history as the stimulus sees it, kept only to steer gets away
	// from store entries that were never written.
	int unsigned hist_head  = 0;
	int unsigned hist_kept  = 0;
	int unsigned hist_col   = 0;
	int unsigned hist_width = 32'(lhrb_pkg::LINE_WIDTH_RST);
	int unsigned hist_cap   = 32'(lhrb_pkg::LINES_IN_USE_RST);
	bit          hist_written [LINES*COLS];

	// sender burst state
	int burst_left = 0;

	// receiver stall state; the long hold-off is requested by bumping hold_reqs
	int hold_reqs    = 0;
	int hold_seen    = 0;
	int hold_left    = 0;
	int stretch_left = 0;
	int stall_mode   = 0;

	always #2 clk = ~clk;

	line_history_ring_buffer_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.codepoint       (codepoint),
		.line_index      (line_index),
		.copy_limit      (copy_limit),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.ok              (ok),
		.has_char        (has_char),
		.char_out        (char_out),
		.last            (last),
		.line_count      (line_count),
		.lines_committed (lines_committed)
	);

	lhrb_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.codepoint       (codepoint),
		.line_index      (line_index),
		.copy_limit      (copy_limit),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.ok              (ok),
		.has_char        (has_char),
		.char_out        (char_out),
		.last            (last),
		.line_count      (line_count),
		.lines_committed (lines_committed),
		.fail_count      (fail_count),
		.outstanding     (outstanding)
	);

	// Receiver: a long hold-off when asked, otherwise stretches of random length in
	// one of four moods: never stall, stall half the time, stall mostly, alternate.
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (stretch_left == 0) begin
				stall_mode   = $urandom_range(0, 3);
				stretch_left = $urandom_range(10, 80);
			end
			stretch_left--;
			case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= ($urandom_range(0, 1) == 1);
			2:       out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ~out_stall;
			endcase
		end
	end

	// Offer one item and hold it until the transfer, then follow the history and,
	// when the current burst runs out, mostly drop valid for a random gap.
	task automatic send_item(input lhrb_pkg::func_t f, input logic [lhrb_pkg::CP_W-1:0] cp,
			input logic [lhrb_pkg::IDX_W-1:0] idx, input logic [lhrb_pkg::LIM_W-1:0] lim);
		int unsigned slot;
		int unsigned col;
		int gap;
		in_valid   <= 1'b1;
		func       <= f;
		codepoint  <= cp;
		line_index <= idx;
		copy_limit <= lim;
		do
			@(posedge clk);
		while (in_stall);
		case (f)
		lhrb_pkg::FN_PUSH: begin
			slot = hist_head % hist_cap;
			col  = hist_col % COLS;
			hist_written[slot*COLS + col] = 1'b1;
			if (col + 1 >= hist_width) begin
				hist_col  = 0;
				hist_head = (slot + 1) % hist_cap;
				if (hist_kept < hist_cap)
					hist_kept++;
			end else begin
				hist_col = col + 1;
			end
		end
		lhrb_pkg::FN_GET: ;
		default: begin
			hist_head = 0;
			hist_kept = 0;
			hist_col  = 0;
		end
		endcase
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Stop offering and wait until every expected result has been taken.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// Write one register while the block is idle and follow the clamped value.
	task automatic cfg_write(input logic [lhrb_pkg::CFG_IDX_W-1:0] idx,
			input logic [lhrb_pkg::CFG_DATA_W-1:0] data);
		int unsigned v;
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		if (idx == lhrb_pkg::REG_LINE_WIDTH) begin
			v = 32'(data[lhrb_pkg::WIDTH_CFG_W-1:0]);
			hist_width = (v < 1) ? 1 : (v > COLS) ? COLS : v;
		end else begin
			v = 32'(data[lhrb_pkg::CAP_CFG_W-1:0]);
			hist_cap = (v < 1) ? 1 : (v > LINES) ? LINES : v;
		end
	endtask

	// Register settings and item mix of each random phase.
	task automatic phase_plan(input int p, output int w, output int c, output int n,
			output int push_pct, output int clr_pct);
		case (p)
		0:       begin w = 3;   c = 4;   n = 12; push_pct = 65; clr_pct = 4; end
		1:       begin w = 1;   c = 2;   n = 10; push_pct = 55; clr_pct = 4; end
		2:       begin w = 64;  c = 3;   n = 40; push_pct = 88; clr_pct = 1; end
		3:       begin w = 5;   c = 2;   n = 10; push_pct = 50; clr_pct = 4; end
		4:       begin w = 127; c = 0;   n = 8;  push_pct = 55; clr_pct = 4; end
		5:       begin w = 0;   c = 511; n = 30; push_pct = 92; clr_pct = 0; end
		6: begin
			w = $urandom_range(1, 64);
			c = $urandom_range(1, 16);
			n = 12; push_pct = 60; clr_pct = 4;
		end
		default: begin w = 8;   c = 256; n = 12; push_pct = 60; clr_pct = 4; end
		endcase
	endtask

	// One random item: mostly pushes and gets of retained lines, some gets out of
	// range, now and then a clear or a full reset. Unused fields carry noise.
	task automatic random_item(input int push_pct, input int clr_pct);
		int r;
		lhrb_pkg::func_t f;
		logic [lhrb_pkg::CP_W-1:0] cp;
		logic [lhrb_pkg::IDX_W-1:0] idx;
		logic [lhrb_pkg::LIM_W-1:0] lim;
		int unsigned slot;
		int unsigned safe;
		int unsigned n;
		case ($urandom_range(0, 7))
		0:       cp = '0;
		1:       cp = CP_TOP;
		default: cp = lhrb_pkg::CP_W'($urandom_range(0, 1114111));
		endcase
		idx = lhrb_pkg::IDX_W'($urandom_range(0, 255));
		lim = lhrb_pkg::LIM_W'($urandom_range(0, 64));
		r = $urandom_range(0, 99);
		if (r < push_pct) begin
			f = lhrb_pkg::FN_PUSH;
		end else if (r < 100 - clr_pct) begin
			f = lhrb_pkg::FN_GET;
			if (hist_kept > 0 && $urandom_range(0, 4) != 0) begin
				case ($urandom_range(0, 3))
				0:       idx = '0;
				1:       idx = lhrb_pkg::IDX_W'(hist_kept - 1);
				default: idx = lhrb_pkg::IDX_W'($urandom_range(0, hist_kept - 1));
				endcase
			end
			case ($urandom_range(0, 3))
			0:       lim = '0;
			1:       lim = 7'd64;
			2:       lim = lhrb_pkg::LIM_W'(hist_width);
			default: ;
			endcase
			// cut the copy short of any column that was never written
			if (idx < hist_kept) begin
				slot = ((hist_head % hist_cap) + 2*hist_cap - 1 - (idx % hist_cap)) % hist_cap;
				safe = 0;
				while (safe < COLS && hist_written[slot*COLS + safe])
					safe++;
				n = (hist_width < lim) ? hist_width : lim;
				if (n > safe)
					lim = lhrb_pkg::LIM_W'(safe);
			end
		end else begin
			f = ($urandom_range(0, 1) == 1) ? lhrb_pkg::FN_CLEAR : lhrb_pkg::FN_RESET;
		end
		send_item(f, cp, idx, lim);
	endtask

	initial begin
		int w;
		int c;
		int n;
		int push_pct;
		int clr_pct;
		logic [1:0] junk;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: gets of an empty history, then narrow lines in a single slot.
		send_item(lhrb_pkg::FN_GET, 21'd5, 8'd0, 7'd64);
		send_item(lhrb_pkg::FN_GET, 21'd5, 8'd255, 7'd0);
		wait_idle();
		cfg_write(lhrb_pkg::REG_LINE_WIDTH, 9'd2);
		cfg_write(lhrb_pkg::REG_LINES_IN_USE, 9'd0);
		send_item(lhrb_pkg::FN_PUSH, 21'd0, 8'd255, 7'd64);
		send_item(lhrb_pkg::FN_PUSH, CP_TOP, 8'd0, 7'd0);
		send_item(lhrb_pkg::FN_GET, 21'd0, 8'd0, 7'd64);
		send_item(lhrb_pkg::FN_GET, 21'd0, 8'd0, 7'd0);
		send_item(lhrb_pkg::FN_GET, 21'd0, 8'd0, 7'd1);
		send_item(lhrb_pkg::FN_GET, 21'd0, 8'd1, 7'd64);
		// overwrite the only slot; the count stays at one
		send_item(lhrb_pkg::FN_PUSH, 21'h0AAAAA, 8'd0, 7'd0);
		send_item(lhrb_pkg::FN_PUSH, 21'h055555, 8'd0, 7'd0);
		send_item(lhrb_pkg::FN_GET, 21'd0, 8'd0, 7'd64);
		// the line being built reuses the only slot, and clear discards it
		send_item(lhrb_pkg::FN_PUSH, 21'h0F0F0F, 8'd0, 7'd0);
		send_item(lhrb_pkg::FN_GET, 21'd0, 8'd0, 7'd64);
		send_item(lhrb_pkg::FN_CLEAR, 21'd0, 8'd0, 7'd0);
		send_item(lhrb_pkg::FN_GET, 21'd0, 8'd0, 7'd64);
		send_item(lhrb_pkg::FN_PUSH, 21'h0F0000, 8'd0, 7'd0);
		send_item(lhrb_pkg::FN_PUSH, 21'h00FFFF, 8'd0, 7'd0);
		send_item(lhrb_pkg::FN_RESET, 21'd0, 8'd0, 7'd0);
		send_item(lhrb_pkg::FN_GET, 21'd0, 8'd0, 7'd64);
		wait_idle();

		// Random phases, each under its own register settings.
		for (int p = 0; p < PHASES; p++) begin
			phase_plan(p, w, c, n, push_pct, clr_pct);
			junk = 2'($urandom_range(0, 3));
			cfg_write(lhrb_pkg::REG_LINE_WIDTH, {junk, w[lhrb_pkg::WIDTH_CFG_W-1:0]});
			cfg_write(lhrb_pkg::REG_LINES_IN_USE, c[lhrb_pkg::CAP_CFG_W-1:0]);
			// long receiver hold-off while wide lines keep coming
			if (p == 2)
				hold_reqs <= hold_reqs + 1;
			for (int k = 0; k < n; k++) begin
				random_item(push_pct, clr_pct);
				if ($urandom_range(0, 49) == 0)
					wait_idle();
			end
			wait_idle();
		end

		if (fail_count == 0 && outstanding == 0)
			$display("line_history_ring_buffer_unit_test passed");
		else
			$display("line_history_ring_buffer_unit_test failed");
		$finish;
	end

	// Hard stop for a hung handshake.
	initial begin
		#4000000;
		$display("line_history_ring_buffer_unit_test failed");
		$finish;
	end

endmodule

### sim.f
design/lhrb_pkg.sv
design/lhrb_rem.sv
design/lhrb_front.sv
design/lhrb_fifo.sv
design/lhrb_back.sv
design/line_history_ring_buffer_unit.sv
dv/lhrb_checker.sv
dv/line_history_ring_buffer_unit_test.sv
